// ===== rtl/ptu_pkg.sv =====
// ----------------------------------------------------------------------------
// ptu_pkg
// Types and codes shared by the particle table update block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptu_pkg;

  localparam logic CMD_SPAWN = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] KIND_REPORT  = 2'd0;
  localparam logic [1:0] KIND_SPAWNED = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;

  typedef struct packed {
    logic               command;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic        [11:0] heading;
    logic        [11:0] start_speed;
    logic        [15:0] life_ms;
    logic        [7:0]  red;
    logic        [7:0]  green;
    logic        [7:0]  blue;
    logic        [7:0]  start_alpha;
    logic        [9:0]  frame_ms;
  } ptu_in_t;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [11:0] out_heading;
    logic        [7:0]  out_red;
    logic        [7:0]  out_green;
    logic        [7:0]  out_blue;
    logic        [7:0]  out_alpha;
    logic               last;
  } ptu_out_t;

endpackage

`default_nettype wire

// ===== rtl/particle_table_update.sv =====
// ----------------------------------------------------------------------------
// particle_table_update
// Ordered particle table with spawn, per-frame motion, fade and compaction.
// ----------------------------------------------------------------------------
// Input requests arrive on in_valid/in_ready with a ptu_in_t payload; results
// leave on out_valid/out_ready with a ptu_out_t payload held in an output
// register. A spawn request waits for a free output register and yields
// one result (spawned or dropped when the table is full). A tick request walks
// the table once: each entry is read from the particle RAM, advanced and
// written back compacted in place. A moving entry runs its sine and cosine
// polynomials and the motion scale through one shared multiplier, and its
// three restoring divisions share one divider; a still or dead entry skips
// that arithmetic. Surviving entries are reported in order, the last
// one flagged, each report one entry behind the walk. A new request is taken
// only once the previous one is finished. When out_ready is low the walk
// waits at the next report. Reset empties the table (the RAM is not cleared;
// entries beyond the live count are never read).
// ----------------------------------------------------------------------------
`default_nettype none

module particle_table_update #(
  parameter int MAX_PARTICLES   = 64,
  parameter int TRIG_TABLE_BITS = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ptu_pkg::ptu_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ptu_pkg::ptu_out_t     out_data
);
  import ptu_pkg::*;

  localparam int AW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW    = $clog2(MAX_PARTICLES + 1);
  localparam int TB    = TRIG_TABLE_BITS;
  localparam int PSH   = 26 - TB;
  localparam int QB    = TB - 2;
  localparam logic [16:0] SIN_A   = 17'd102944;
  localparam logic [16:0] SIN_B   = 17'd42048;
  localparam logic [21:0] SIN_C   = 22'd4640;
  localparam logic [16:0] AGE_MAX = 17'd131071;
  localparam logic [3:0]  MOVE_STEPS  = 4'd12;
  localparam logic [3:0]  ALPHA_STEPS = 4'd8;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [11:0] hd;
    logic        [11:0] spd;
    logic        [15:0] life;
    logic        [16:0] age;
    logic        [23:0] color;
    logic        [7:0]  alpha;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SPW, S_RD, S_LD, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_DV, S_WB, S_FIN
  } state_t;

  typedef enum logic [1:0] {AX_COS, AX_SIN, AX_ALPHA} axis_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767)       sat16 = 16'sh7FFF;
    else if (v < -18'sd32768) sat16 = 16'sh8000;
    else                      sat16 = v[15:0];
  endfunction

  // particle RAM
  entry_t mem [MAX_PARTICLES];
  entry_t rd_data_r;
  logic   we;
  logic [AW-1:0] wa, ra;
  entry_t wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  state_t        state_r;
  axis_t         axis_r;
  ptu_in_t       req_r;
  logic [CW-1:0] count_r, i_r, j_r;
  logic          have_pend_r;
  ptu_out_t      pend_r;
  logic          out_valid_r;
  ptu_out_t      out_data_r;
  logic [9:0]    frame_r;
  entry_t        cur_r;
  logic          act_r;
  logic [16:0]   x_r;
  logic [1:0]    q_r;
  logic [21:0]   fs_r;
  logic [15:0]   diff_r;
  logic [41:0]   den_r;
  logic [16:0]   x2_r, u_r, w_r, mag_r;
  logic [37:0]   p1_r;
  logic [54:0]   rem_r;
  logic [52:0]   dsh_r;
  logic [11:0]   quo_r;
  logic [3:0]    cnt_r;
  logic [11:0]   qx_r, qy_r;
  logic [7:0]    alpha_q_r;

  logic out_free;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // phase split of the entry just read
  logic [25:0] ph_wide;
  logic [TB-1:0] ph;
  logic [31:0] xw;
  always_comb begin
    ph_wide = {rd_data_r.hd, 14'b0} >> PSH;
    ph      = ph_wide[TB-1:0];
    xw      = (32'(ph[QB-1:0]) << 16) >> QB;
  end

  // current axis operand
  logic [1:0]  qa;
  logic [16:0] xa;
  always_comb begin
    qa = (axis_r == AX_COS) ? 2'(q_r + 2'd1) : q_r;
    xa = qa[0] ? 17'(17'd65536 - x_r) : x_r;
  end

  logic [38:0] mul_a;
  logic [21:0] mul_b;
  logic [60:0] mul_p;
  always_comb begin
    case (state_r)
      S_T1:    begin mul_a = 39'(xa);    mul_b = 22'(xa);     end
      S_T2:    begin mul_a = 39'(x2_r);  mul_b = SIN_C;       end
      S_T3:    begin mul_a = 39'(x2_r);  mul_b = 22'(u_r);    end
      S_T4:    begin mul_a = 39'(xa);    mul_b = 22'(w_r);    end
      S_T5:    begin mul_a = 39'(mag_r); mul_b = fs_r;        end
      S_T6:    begin mul_a = 39'(p1_r);  mul_b = 22'(diff_r); end
      default: begin mul_a = '0;         mul_b = '0;          end
    endcase
    mul_p = 61'(mul_a) * 61'(mul_b);
  end

  // divider step
  logic        dv_bit;
  logic [11:0] dv_q;
  always_comb begin
    dv_bit = (rem_r >= 55'(dsh_r));
    dv_q   = {quo_r[10:0], dv_bit};
  end

  // write-back values
  logic              negc, negs;
  logic signed [17:0] dx, dy, xs, ys;
  logic [17:0]       age_sum;
  logic [16:0]       age_new;
  logic              survive;
  entry_t            upd;
  ptu_out_t          rep;
  always_comb begin
    negc    = 2'(q_r + 2'd1) >> 1 != 2'd0;
    negs    = q_r[1];
    dx      = negc ? -$signed(18'(qx_r)) : $signed(18'(qx_r));
    dy      = negs ? -$signed(18'(qy_r)) : $signed(18'(qy_r));
    xs      = 18'(cur_r.x) + dx;
    ys      = 18'(cur_r.y) - dy;
    age_sum = 18'(cur_r.age) + 18'(frame_r);
    age_new = (age_sum > 18'(AGE_MAX)) ? AGE_MAX : age_sum[16:0];
    upd     = cur_r;
    upd.age = age_new;
    if (act_r) begin
      upd.x     = sat16(xs);
      upd.y     = sat16(ys);
      upd.alpha = alpha_q_r;
    end
    survive         = (age_new <= 17'(cur_r.life));
    rep.kind        = KIND_REPORT;
    rep.pos_x       = upd.x;
    rep.pos_y       = upd.y;
    rep.out_heading = upd.hd;
    rep.out_red     = upd.color[23:16];
    rep.out_green   = upd.color[15:8];
    rep.out_blue    = upd.color[7:0];
    rep.out_alpha   = upd.alpha;
    rep.last        = 1'b0;
  end

  // output register load
  logic     out_load;
  ptu_out_t out_data_nxt;
  always_comb begin
    out_load     = 1'b0;
    out_data_nxt = pend_r;
    case (state_r)
      S_SPW: begin
        out_load          = out_free;
        out_data_nxt      = '0;
        out_data_nxt.last = 1'b1;
        out_data_nxt.kind = (count_r == CW'(MAX_PARTICLES)) ? KIND_DROPPED : KIND_SPAWNED;
      end
      S_WB: begin
        out_load = survive && have_pend_r && out_free;
      end
      S_FIN: begin
        out_load          = have_pend_r && out_free;
        out_data_nxt.last = 1'b1;
      end
      default: out_load = 1'b0;
    endcase
  end

  // RAM port control
  always_comb begin
    we = 1'b0;
    wa = j_r[AW-1:0];
    wd = upd;
    ra = i_r[AW-1:0];
    if (state_r == S_SPW && out_free && count_r != CW'(MAX_PARTICLES)) begin
      we       = 1'b1;
      wa       = count_r[AW-1:0];
      wd.x     = req_r.start_x;
      wd.y     = req_r.start_y;
      wd.hd    = req_r.heading;
      wd.spd   = req_r.start_speed;
      wd.life  = req_r.life_ms;
      wd.age   = '0;
      wd.color = {req_r.red, req_r.green, req_r.blue};
      wd.alpha = req_r.start_alpha;
    end else if (state_r == S_WB && survive && (!have_pend_r || out_free)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_data_nxt;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r       <= in_data;
            frame_r     <= in_data.frame_ms;
            i_r         <= '0;
            j_r         <= '0;
            have_pend_r <= 1'b0;
            if (in_data.command == CMD_SPAWN) state_r <= S_SPW;
            else if (count_r == '0)           state_r <= S_FIN;
            else                              state_r <= S_RD;
          end
        end
        S_SPW: begin
          if (out_free) begin
            if (count_r != CW'(MAX_PARTICLES)) count_r <= CW'(count_r + 1'b1);
            state_r <= S_IDLE;
          end
        end
        S_RD: state_r <= S_LD;
        S_LD: begin
          cur_r  <= rd_data_r;
          x_r    <= xw[16:0];
          q_r    <= ph[TB-1:TB-2];
          fs_r   <= 22'(frame_r) * 22'(rd_data_r.spd);
          diff_r <= 16'(rd_data_r.life - rd_data_r.age[15:0]);
          den_r  <= {26'(26'(rd_data_r.life) * 26'd1000), 16'b0};
          axis_r <= AX_COS;
          act_r  <= (rd_data_r.life != '0) && (rd_data_r.age < 17'(rd_data_r.life))
                    && (rd_data_r.spd != '0);
          if ((rd_data_r.life != '0) && (rd_data_r.age < 17'(rd_data_r.life))
              && (rd_data_r.spd != '0)) state_r <= S_T1;
          else                           state_r <= S_WB;
        end
        S_T1: begin x2_r <= mul_p[32:16]; state_r <= S_T2; end
        S_T2: begin u_r <= 17'(SIN_B - mul_p[32:16]); state_r <= S_T3; end
        S_T3: begin w_r <= 17'(SIN_A - mul_p[32:16]); state_r <= S_T4; end
        S_T4: begin mag_r <= mul_p[32:16]; state_r <= S_T5; end
        S_T5: begin p1_r <= mul_p[37:0]; state_r <= S_T6; end
        S_T6: begin
          rem_r   <= 55'(mul_p[53:0]) + 55'({den_r, 1'b0} >> 2);
          dsh_r   <= 53'(den_r) << 11;
          quo_r   <= '0;
          cnt_r   <= MOVE_STEPS;
          state_r <= S_DV;
        end
        S_DV: begin
          if (cnt_r == 4'd1 && axis_r == AX_SIN) begin
            qy_r   <= dv_q;
            axis_r <= AX_ALPHA;
            rem_r  <= 55'(24'(diff_r) * 24'd255);
            dsh_r  <= 53'(cur_r.life) << 7;
            quo_r  <= '0;
            cnt_r  <= ALPHA_STEPS;
          end else begin
            if (dv_bit) rem_r <= 55'(rem_r - 55'(dsh_r));
            dsh_r <= dsh_r >> 1;
            quo_r <= dv_q;
            cnt_r <= 4'(cnt_r - 1'b1);
            if (cnt_r == 4'd1) begin
              case (axis_r)
                AX_COS: begin
                  qx_r    <= dv_q;
                  axis_r  <= AX_SIN;
                  state_r <= S_T1;
                end
                default: begin
                  alpha_q_r <= dv_q[7:0];
                  state_r   <= S_WB;
                end
              endcase
            end
          end
        end
        S_WB: begin
          if (!survive || !have_pend_r || out_free) begin
            if (survive) begin
              j_r         <= CW'(j_r + 1'b1);
              pend_r      <= rep;
              have_pend_r <= 1'b1;
            end
            i_r <= CW'(i_r + 1'b1);
            if (CW'(i_r + 1'b1) == count_r) state_r <= S_FIN;
            else                            state_r <= S_RD;
          end
        end
        S_FIN: begin
          if (!have_pend_r || out_free) begin
            have_pend_r <= 1'b0;
            count_r     <= j_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
